@@ sv/bp_pkg.sv @@
// Shared constants and codes for the MSB-first bit packer.
package bp_pkg;

  // Field widths of the input and result words
  localparam int CNT_W  = 7;
  localparam int CODE_W = 64;
  localparam int BYTE_W = 8;
  localparam int HELD_W = 3;
  localparam int TVAL_W = 4;

  // Item kinds
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  // Trailer value when the stream ends on a byte boundary
  localparam logic [TVAL_W-1:0] TRAILER_ALIGNED = 4'd8;

endpackage

@@ sv/bp_in_if.sv @@
// Input channel of the bit packer: add or finish words.
interface bp_in_if;
  logic                         valid;
  logic                         ready;
  logic                         kind;
  logic [bp_pkg::CNT_W-1:0]     bit_count;
  logic [bp_pkg::CODE_W-1:0]    code_value;

  modport source (output valid, kind, bit_count, code_value, input ready);
  modport sink   (input valid, kind, bit_count, code_value, output ready);
endinterface

@@ sv/bp_out_if.sv @@
// Output channel of the bit packer: one byte per word.
interface bp_out_if;
  logic                         valid;
  logic                         ready;
  logic [bp_pkg::BYTE_W-1:0]    out_byte;
  logic                         is_trailer;
  logic                         last;

  modport source (output valid, out_byte, is_trailer, last, input ready);
  modport sink   (input valid, out_byte, is_trailer, last, output ready);
endinterface

@@ sv/bp_front.sv @@
// Front end: accepts words, merges code bits with the pending bits, queues byte jobs.
module bp_front #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  bp_in_if.sink       in_ch,
  input  logic        q_full,
  output logic        push,
  output logic [8*((MAX_CODE_BITS+7)/8+1)+$clog2((MAX_CODE_BITS+7)/8+1)+5-1:0] push_entry
);

  localparam int NB   = (MAX_CODE_BITS + 7) / 8 + 1;
  localparam int IDXW = $clog2(NB);
  localparam int W    = 8 * NB;
  localparam int VW   = W - 8;
  localparam int SHW  = $clog2(VW + 1);

  typedef struct packed {
    logic [NB-1:0][7:0]                data;
    logic [IDXW-1:0]                   nbytes;
    logic                              trailer;
    logic [bp_pkg::TVAL_W-1:0]         tval;
  } entry_t;

  logic [6:0]                    pend;
  logic [bp_pkg::HELD_W-1:0]     held;

  logic                          accept;
  logic [bp_pkg::CNT_W-1:0]      cnt_sat;
  logic [SHW-1:0]                lshift;
  logic [VW-1:0]                 v_al;
  logic [7:0]                    pend_al;
  logic [W-1:0]                  word;
  logic [NB-1:0][7:0]            bytes;
  logic [bp_pkg::CNT_W-1:0]      total;
  logic [IDXW-1:0]               nfull;
  logic [bp_pkg::HELD_W-1:0]     held_new;
  logic [7:0]                    rem;
  logic [6:0]                    pend_new;
  entry_t                        entry;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && in_ch.ready;

  // Clamp the count and left-align the code bits
  always_comb begin
    cnt_sat = (in_ch.bit_count > bp_pkg::CNT_W'(MAX_CODE_BITS)) ?
              bp_pkg::CNT_W'(MAX_CODE_BITS) : in_ch.bit_count;
    lshift  = SHW'(VW) - SHW'(cnt_sat);
    v_al    = VW'(in_ch.code_value[MAX_CODE_BITS-1:0]) << lshift;
    pend_al = 8'({pend, 1'b0} << (3'd7 - held));
    word    = {pend_al, {VW{1'b0}}} | ({v_al, 8'b0} >> held);
  end

  // Split into bytes, first byte at index zero
  always_comb begin
    for (int k = 0; k < NB; k++) begin
      bytes[k] = word[W-1-8*k -: 8];
    end
  end

  // Count full bytes and keep the leftover bits right aligned
  always_comb begin
    total    = bp_pkg::CNT_W'(held) + cnt_sat;
    nfull    = IDXW'(total[6:3]);
    held_new = total[2:0];
    rem      = bytes[nfull];
    pend_new = 7'(rem >> (4'd8 - {1'b0, held_new}));
  end

  // Build the job for the back end
  always_comb begin
    if (in_ch.kind == bp_pkg::KIND_FINISH) begin
      entry.data    = '0;
      entry.data[0] = pend_al;
      entry.nbytes  = IDXW'(held != '0);
      entry.trailer = 1'b1;
      entry.tval    = (held != '0) ? {1'b0, held} : bp_pkg::TRAILER_ALIGNED;
    end else begin
      entry.data    = bytes;
      entry.nbytes  = nfull;
      entry.trailer = 1'b0;
      entry.tval    = '0;
    end
  end

  assign push       = accept && (in_ch.kind == bp_pkg::KIND_FINISH || nfull != '0);
  assign push_entry = entry;

  // Advance the pending bits on every accepted add word; a finish clears them
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
      held <= '0;
    end else if (accept) begin
      if (in_ch.kind == bp_pkg::KIND_FINISH) begin
        pend <= '0;
        held <= '0;
      end else begin
        pend <= pend_new;
        held <= held_new;
      end
    end
  end

`ifndef SYNTHESIS
  a_pend_clean: assert property (@(posedge clk) disable iff (rst)
    (held == '0) |-> (pend == '0))
    else $error("pending bits set with empty count");

  a_finish_clears: assert property (@(posedge clk) disable iff (rst)
    (accept && in_ch.kind == bp_pkg::KIND_FINISH) |=> (held == '0 && pend == '0))
    else $error("finish did not clear pending state");
`endif

endmodule

@@ sv/bp_queue.sv @@
// Two-entry job queue between the front end and the byte emitter.
module bp_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] push_data,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] head,
  output logic         empty
);

  localparam int DEPTH = 2;

  logic [W-1:0] mem [DEPTH];
  logic         wptr;
  logic         rptr;
  logic [1:0]   count;

  assign full  = (count == 2'(DEPTH));
  assign empty = (count == '0);
  assign head  = mem[rptr];

  // Store pushed jobs
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= '0;
    end else begin
      if (push) wptr <= !wptr;
      if (pop)  rptr <= !rptr;
      if (push && !pop)      count <= count + 2'd1;
      else if (pop && !push) count <= count - 2'd1;
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'(DEPTH))
    else $error("queue occupancy out of range");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (rst)
    empty |-> !pop)
    else $error("pop from empty queue");
`endif

endmodule

@@ sv/bp_back.sv @@
// Back end: walks each queued job and emits its bytes into the output register.
module bp_back #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        empty,
  input  logic [8*((MAX_CODE_BITS+7)/8+1)+$clog2((MAX_CODE_BITS+7)/8+1)+5-1:0] head,
  output logic        pop,
  bp_out_if.source    out_ch
);

  localparam int NB   = (MAX_CODE_BITS + 7) / 8 + 1;
  localparam int IDXW = $clog2(NB);

  typedef struct packed {
    logic [NB-1:0][7:0]                data;
    logic [IDXW-1:0]                   nbytes;
    logic                              trailer;
    logic [bp_pkg::TVAL_W-1:0]         tval;
  } entry_t;

  entry_t                      job;
  logic [IDXW-1:0]             idx;
  logic                        ovalid;
  logic [7:0]                  obyte;
  logic                        otrailer;
  logic                        olast;

  logic                        load;
  logic                        is_data;
  logic [7:0]                  byte_sel;
  logic                        trl_sel;
  logic                        last_sel;

  assign job  = head;
  assign load = !empty && (!ovalid || out_ch.ready);

  // Pick the next byte of the head job
  always_comb begin
    is_data = idx < job.nbytes;
    if (is_data) begin
      byte_sel = job.data[idx];
      trl_sel  = 1'b0;
      last_sel = !job.trailer && ({1'b0, idx} + 1'b1 == {1'b0, job.nbytes});
    end else begin
      byte_sel = 8'(job.tval);
      trl_sel  = 1'b1;
      last_sel = 1'b1;
    end
  end

  assign pop = load && last_sel;

  // Step through the job and hold the output word until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      idx    <= '0;
      ovalid <= 1'b0;
    end else begin
      if (load) begin
        idx    <= last_sel ? '0 : idx + 1'b1;
        ovalid <= 1'b1;
      end else if (out_ch.ready) begin
        ovalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      obyte    <= byte_sel;
      otrailer <= trl_sel;
      olast    <= last_sel;
    end
  end

  assign out_ch.valid      = ovalid;
  assign out_ch.out_byte   = obyte;
  assign out_ch.is_trailer = otrailer;
  assign out_ch.last       = olast;

`ifndef SYNTHESIS
  a_trailer_last: assert property (@(posedge clk) disable iff (rst)
    (ovalid && otrailer) |-> olast)
    else $error("trailer byte not marked last");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    empty |-> (idx == '0))
    else $error("byte index left mid-job with empty queue");
`endif

endmodule

@@ sv/msb_first_bit_packer.sv @@
// Top level of the MSB-first bit packer: front end, job queue and byte emitter.
// Codes are packed most significant bit first into bytes. The front end accepts
// one word per cycle while its two-entry job queue has room and merges the code
// with the pending bits in that same cycle. The back end sends one byte per
// cycle through a registered output while the receiver takes each byte; a word
// yields up to (MAX_CODE_BITS+7)/8 bytes for an add, one or two for a finish
// (the flushed partial byte, if any, and the trailer). The output port width of
// one byte sets the sustained rate; the first byte of a word passes through the
// job queue and the output register before it is valid on the output. An add
// that completes no byte pushes no job and yields no output byte.
module msb_first_bit_packer #(
  parameter int MAX_CODE_BITS = 64
) (
  input  logic     clk,
  input  logic     rst,
  bp_in_if.sink    in_ch,
  bp_out_if.source out_ch
);

  localparam int NB   = (MAX_CODE_BITS + 7) / 8 + 1;
  localparam int IDXW = $clog2(NB);
  localparam int EW   = 8 * NB + IDXW + 1 + bp_pkg::TVAL_W;

  logic          push;
  logic [EW-1:0] push_entry;
  logic          q_full;
  logic          pop;
  logic [EW-1:0] head;
  logic          empty;

  bp_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  bp_queue #(.W(EW)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_entry),
    .full      (q_full),
    .pop       (pop),
    .head      (head),
    .empty     (empty)
  );

  bp_back #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_back (
    .clk    (clk),
    .rst    (rst),
    .empty  (empty),
    .head   (head),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule
